[src/gds_pkg.sv]
// Shared constants and codes of the grid ray walk wall search block.
package gds_pkg;

  localparam int unsigned MAP_COLS_MAX_DEF = 64;
  localparam int unsigned MAP_ROWS_MAX_DEF = 64;

  localparam int unsigned CFG_W    = 7;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned COORD_IW = 6;
  localparam int unsigned COORD_OW = 8;

  localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 7'd64;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam logic [1:0] CELL_EMPTY       = 2'd0;
  localparam logic [1:0] CELL_WALL        = 2'd1;
  localparam logic [1:0] CELL_DOOR_OPEN   = 2'd2;
  localparam logic [1:0] CELL_DOOR_CLOSED = 2'd3;

  localparam logic [1:0] OUT_LEFT_MAP   = 2'd0;
  localparam logic [1:0] OUT_WALL_HIT   = 2'd1;
  localparam logic [1:0] OUT_DOOR_HIT   = 2'd2;
  localparam logic [1:0] OUT_WRITE_DONE = 2'd3;

  typedef struct packed {
    logic              x_lt;
    logic [DIST_W-1:0] sum;
  } alu_res_t;

endpackage

[src/gds_if.sv]
// Valid/ready channel interfaces for cast and write items and their results.
interface gds_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [5:0]         cell_col;
  logic [5:0]         cell_row;
  logic [1:0]         cell_code;
  logic [31:0]        start_dist_x;
  logic [31:0]        start_dist_y;
  logic [31:0]        delta_dist_x;
  logic [31:0]        delta_dist_y;
  logic signed [1:0]  step_col;
  logic signed [1:0]  step_row;

  modport source (
    output valid, func, cell_col, cell_row, cell_code, start_dist_x, start_dist_y,
           delta_dist_x, delta_dist_y, step_col, step_row,
    input  ready
  );
  modport sink (
    input  valid, func, cell_col, cell_row, cell_code, start_dist_x, start_dist_y,
           delta_dist_x, delta_dist_y, step_col, step_row,
    output ready
  );
endinterface

interface gds_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic signed [7:0]  end_col;
  logic signed [7:0]  end_row;
  logic               hit_side;
  logic [31:0]        end_dist_x;
  logic [31:0]        end_dist_y;

  modport source (
    output valid, outcome, end_col, end_row, hit_side, end_dist_x, end_dist_y,
    input  ready
  );
  modport sink (
    input  valid, outcome, end_col, end_row, hit_side, end_dist_x, end_dist_y,
    output ready
  );
endinterface

[src/gds_step_alu.sv]
// Shared side distance unit: axis choice and saturating add.
module gds_step_alu (
  input  logic [gds_pkg::DIST_W-1:0] dist_x_i,
  input  logic [gds_pkg::DIST_W-1:0] dist_y_i,
  input  logic [gds_pkg::DIST_W-1:0] delta_x_i,
  input  logic [gds_pkg::DIST_W-1:0] delta_y_i,
  output gds_pkg::alu_res_t          res_o
);
  import gds_pkg::*;

  logic              x_lt;
  logic [DIST_W-1:0] op_a;
  logic [DIST_W-1:0] op_b;
  logic [DIST_W:0]   sum_w;

  assign x_lt  = dist_x_i < dist_y_i;
  assign op_a  = x_lt ? dist_x_i : dist_y_i;
  assign op_b  = x_lt ? delta_x_i : delta_y_i;
  assign sum_w = {1'b0, op_a} + {1'b0, op_b};

  assign res_o.x_lt = x_lt;
  assign res_o.sum  = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];

endmodule

[src/gds_map_ram.sv]
// Cell map memory with registered read and a clearing sweep after reset.
module gds_map_ram #(
  parameter int unsigned DEPTH = gds_pkg::MAP_COLS_MAX_DEF * gds_pkg::MAP_ROWS_MAX_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o,
  output logic          busy_o
);
  import gds_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [1:0]    mem [DEPTH];
  logic [AW-1:0] clr_cnt_q;
  logic          busy_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;

  assign we    = busy_q | we_i;
  assign waddr = busy_q ? clr_cnt_q : waddr_i;
  assign wdata = busy_q ? CELL_EMPTY : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign busy_o = busy_q;

endmodule

[src/grid_ray_dda_wall_search_unit.sv]
// Top level of the grid ray walk wall search block: sequencer and result register.
//
// Input channel in_i carries write items (func 0) and cast items (func 1);
// output channel out_o returns exactly one result per item, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 map_width, 1 map_height) at any rising edge; write only while idle.
// After reset the map is swept to empty, one cell a cycle, over all
// MAP_COLS_MAX * MAP_ROWS_MAX cells (4096 at the defaults); in_i.ready stays
// low meanwhile.
// A write item passes through ST_DONE to its result in the output register.
// A cast item runs ST_STEP and ST_TEST once per walk step (ST_STEP for the
// shared side distance adder, bounds check and map read request, ST_TEST for
// the registered read data and cell test), then ST_DONE; a last step that leaves
// the map skips the map read and ST_TEST; the walk length is set by the map
// contents and the ray, and is at most MAP_COLS_MAX + MAP_ROWS_MAX steps.
// One item is worked on at a time. The output register holds a finished
// result while the receiver stalls; the next item is still accepted and is
// worked on, and its result waits until the register is free.
module grid_ray_dda_wall_search_unit #(
  parameter int unsigned MAP_COLS_MAX = gds_pkg::MAP_COLS_MAX_DEF,
  parameter int unsigned MAP_ROWS_MAX = gds_pkg::MAP_ROWS_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gds_pkg::CFG_W-1:0] cfg_wdata_i,
  gds_in_if.sink                    in_i,
  gds_out_if.source                 out_o
);
  import gds_pkg::*;

  localparam int unsigned DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CMAXC = (MAP_COLS_MAX > 64) ? MAP_COLS_MAX : 64;
  localparam int unsigned CMAXR = (MAP_ROWS_MAX > 64) ? MAP_ROWS_MAX : 64;
  localparam int unsigned CWC   = $clog2(CMAXC) + 2;
  localparam int unsigned CWR   = $clog2(CMAXR) + 2;
  localparam int unsigned LIM   = MAP_COLS_MAX + MAP_ROWS_MAX;
  localparam int unsigned NW    = $clog2(LIM + 1);

  localparam logic [AW-1:0]  COLS_A = AW'(MAP_COLS_MAX);
  localparam logic [CWC-2:0] COLS_C = (CWC-1)'(MAP_COLS_MAX);
  localparam logic [CWR-2:0] ROWS_C = (CWR-1)'(MAP_ROWS_MAX);
  localparam logic [NW-1:0]  LIM_N  = NW'(LIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_TEST,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      map_width_q;
  logic [CFG_W-1:0]      map_height_q;
  logic [DIST_W-1:0]     dx_q;
  logic [DIST_W-1:0]     dy_q;
  logic [DIST_W-1:0]     ddx_q;
  logic [DIST_W-1:0]     ddy_q;
  logic signed [1:0]     sc_q;
  logic signed [1:0]     sr_q;
  logic signed [CWC-1:0] col_q;
  logic signed [CWR-1:0] row_q;
  logic                  side_q;
  logic [1:0]            outcome_q;
  logic [NW-1:0]         n_q;
  logic                  out_valid_q;
  logic [1:0]            out_outcome_q;
  logic [COORD_OW-1:0]   out_col_q;
  logic [COORD_OW-1:0]   out_row_q;
  logic                  out_side_q;
  logic [DIST_W-1:0]     out_dx_q;
  logic [DIST_W-1:0]     out_dy_q;

  alu_res_t              alu_res;
  logic signed [CWC-1:0] col_d;
  logic signed [CWR-1:0] row_d;
  logic [CWC-2:0]        wid;
  logic [CWR-2:0]        hei;
  logic [CWC-2:0]        wid_cfg;
  logic [CWR-2:0]        hei_cfg;
  logic                  oob;
  logic                  accept;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [1:0]            ram_rdata;
  logic                  clr_busy;

  gds_step_alu u_alu (
    .dist_x_i  (dx_q),
    .dist_y_i  (dy_q),
    .delta_x_i (ddx_q),
    .delta_y_i (ddy_q),
    .res_o     (alu_res)
  );

  gds_map_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.cell_code),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .busy_o  (clr_busy)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign accept     = in_i.valid && in_i.ready;

  assign ram_we    = accept && (in_i.func == FUNC_WRITE)
                     && ({{(32-COORD_IW){1'b0}}, in_i.cell_col} < MAP_COLS_MAX)
                     && ({{(32-COORD_IW){1'b0}}, in_i.cell_row} < MAP_ROWS_MAX);
  assign ram_waddr = AW'(AW'(in_i.cell_row) * COLS_A + AW'(in_i.cell_col));

  assign wid_cfg = (CWC-1)'(map_width_q);
  assign hei_cfg = (CWR-1)'(map_height_q);
  assign wid     = (wid_cfg > COLS_C) ? COLS_C : wid_cfg;
  assign hei     = (hei_cfg > ROWS_C) ? ROWS_C : hei_cfg;

  assign col_d = alu_res.x_lt ? col_q + {{(CWC-2){sc_q[1]}}, sc_q} : col_q;
  assign row_d = alu_res.x_lt ? row_q : row_q + {{(CWR-2){sr_q[1]}}, sr_q};

  assign oob = col_d[CWC-1] || row_d[CWR-1]
               || (col_d[CWC-2:0] >= wid) || (row_d[CWR-2:0] >= hei);

  assign ram_re    = (state_q == ST_STEP) && !oob;
  assign ram_raddr = AW'(AW'(row_d[CWR-2:0]) * COLS_A + AW'(col_d[CWC-2:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_wdata_i;
        default:        map_width_q  <= map_width_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_i.func == FUNC_CAST) begin
              dx_q    <= in_i.start_dist_x;
              dy_q    <= in_i.start_dist_y;
              ddx_q   <= in_i.delta_dist_x;
              ddy_q   <= in_i.delta_dist_y;
              sc_q    <= in_i.step_col;
              sr_q    <= in_i.step_row;
              col_q   <= $signed(CWC'(in_i.cell_col));
              row_q   <= $signed(CWR'(in_i.cell_row));
              side_q  <= 1'b0;
              n_q     <= '0;
              state_q <= ST_STEP;
            end else begin
              dx_q      <= '0;
              dy_q      <= '0;
              col_q     <= '0;
              row_q     <= '0;
              side_q    <= 1'b0;
              outcome_q <= OUT_WRITE_DONE;
              state_q   <= ST_DONE;
            end
          end
        end
        ST_STEP: begin
          if (alu_res.x_lt) begin
            dx_q <= alu_res.sum;
          end else begin
            dy_q <= alu_res.sum;
          end
          col_q  <= col_d;
          row_q  <= row_d;
          side_q <= !alu_res.x_lt;
          n_q    <= n_q + 1'b1;
          if (oob) begin
            outcome_q <= OUT_LEFT_MAP;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          priority if (ram_rdata == CELL_WALL) begin
            outcome_q <= OUT_WALL_HIT;
            state_q   <= ST_DONE;
          end else if (ram_rdata == CELL_DOOR_CLOSED) begin
            outcome_q <= OUT_DOOR_HIT;
            state_q   <= ST_DONE;
          end else if (n_q == LIM_N) begin
            outcome_q <= OUT_LEFT_MAP;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_STEP;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= outcome_q;
            out_col_q     <= col_q[COORD_OW-1:0];
            out_row_q     <= row_q[COORD_OW-1:0];
            out_side_q    <= side_q;
            out_dx_q      <= dx_q;
            out_dy_q      <= dy_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.outcome    = out_outcome_q;
  assign out_o.end_col    = $signed(out_col_q);
  assign out_o.end_row    = $signed(out_row_q);
  assign out_o.hit_side   = out_side_q;
  assign out_o.end_dist_x = out_dx_q;
  assign out_o.end_dist_y = out_dy_q;

`ifndef SYNTH
  a_cast_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.func == FUNC_CAST) |=> state_q == ST_STEP)
    else $error("cast item did not start a walk");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_IDLE && !clr_busy)
    else $error("map write outside idle");

  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= LIM_N)
    else $error("walk step count beyond limit");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !out_o.ready |=> state_q == ST_DONE)
    else $error("result left done state while output register full");
`endif

endmodule
